### rtl/gcpd_pkg.sv
package gcpd_pkg;

    // Field widths of the channels
    localparam int LEVEL_W     = 8;
    localparam int PIX_W       = 12;
    localparam int PROJ_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int BITS_W      = 5;
    localparam int THRESH_W    = 8;
    localparam int PROJ_SIZE_W = 17;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 17;

    // Pair counter holds up to column_bits + row_bits (at most 32)
    localparam int COUNT_W = 6;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CODE_BITS  = 16;
    localparam int DEF_CAM_COORD_BITS = 12;

    // Command codes
    localparam logic CMD_REF  = 1'b0;
    localparam logic CMD_PAIR = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_COLUMN_BITS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_BITS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTRAST    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SHADOW      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PROJ_WIDTH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PROJ_HEIGHT = 3'd5;

    // Reset values of the configuration registers
    localparam logic [BITS_W-1:0]      RST_COLUMN_BITS = 5'd11;
    localparam logic [BITS_W-1:0]      RST_ROW_BITS    = 5'd10;
    localparam logic [THRESH_W-1:0]    RST_CONTRAST    = 8'd5;
    localparam logic [THRESH_W-1:0]    RST_SHADOW      = 8'd40;
    localparam logic [PROJ_SIZE_W-1:0] RST_PROJ_WIDTH  = 17'd1280;
    localparam logic [PROJ_SIZE_W-1:0] RST_PROJ_HEIGHT = 17'd768;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHADOW   = 2'd1,
        STATUS_CONTRAST = 2'd2,
        STATUS_RANGE    = 2'd3
    } status_t;

    // Live configuration, bit counts already clamped
    typedef struct packed {
        logic [BITS_W-1:0]      column_bits;
        logic [BITS_W-1:0]      row_bits;
        logic [THRESH_W-1:0]    contrast_threshold;
        logic [THRESH_W-1:0]    shadow_threshold;
        logic [PROJ_SIZE_W-1:0] projector_width;
        logic [PROJ_SIZE_W-1:0] projector_height;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_row;
        logic [PIX_W-1:0]  pixel_col;
        logic [PROJ_W-1:0] proj_row;
        logic [PROJ_W-1:0] proj_col;
        status_t           status;
    } result_t;

    function automatic logic [LEVEL_W-1:0] abs_diff(
        input logic [LEVEL_W-1:0] a,
        input logic [LEVEL_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### rtl/gcpd_pixel_if.sv
interface gcpd_pixel_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [gcpd_pkg::LEVEL_W-1:0] level_a;
    logic [gcpd_pkg::LEVEL_W-1:0] level_b;
    logic [gcpd_pkg::PIX_W-1:0]   cam_row;
    logic [gcpd_pkg::PIX_W-1:0]   cam_col;

    modport source (
        output valid, command, level_a, level_b, cam_row, cam_col,
        input  ready
    );
    modport sink (
        input  valid, command, level_a, level_b, cam_row, cam_col,
        output ready
    );
endinterface

### rtl/gcpd_result_if.sv
interface gcpd_result_if;
    logic                          valid;
    logic                          ready;
    logic [gcpd_pkg::PIX_W-1:0]    pixel_row;
    logic [gcpd_pkg::PIX_W-1:0]    pixel_col;
    logic [gcpd_pkg::PROJ_W-1:0]   proj_row;
    logic [gcpd_pkg::PROJ_W-1:0]   proj_col;
    logic [gcpd_pkg::STATUS_W-1:0] status;

    modport source (
        output valid, pixel_row, pixel_col, proj_row, proj_col, status,
        input  ready
    );
    modport sink (
        input  valid, pixel_row, pixel_col, proj_row, proj_col, status,
        output ready
    );
endinterface

### rtl/gcpd_cfg_if.sv
interface gcpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gcpd_pkg::CFG_ADDR_W-1:0] addr;
    logic [gcpd_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, addr, data,
        input  ready
    );
    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

### rtl/gray_code_pixel_decoder.sv
// Channel   Dir  Payload                                           Handshake
// pixel     in   command, level_a, level_b, cam_row, cam_col       valid/ready
// result    out  pixel_row, pixel_col, proj_row, proj_col, status  valid/ready
// cfg       in   addr (register index), data                       valid/ready
//
// One item per cycle unless a stall on result holds it; an item enters the input
// register, is decoded against the pixel state in the next cycle and its result
// (after the last pair) is then loaded into the output register.
// Reset clears the handshake and pixel state and loads the register defaults.
// A stall on result holds the input register only when it carries an item
// that completes a pixel; other items keep flowing. cfg is always ready.
module gray_code_pixel_decoder #(
    parameter int MAX_CODE_BITS  = gcpd_pkg::DEF_MAX_CODE_BITS,
    parameter int CAM_COORD_BITS = gcpd_pkg::DEF_CAM_COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    gcpd_pixel_if.sink    pixel,
    gcpd_result_if.source result,
    gcpd_cfg_if.sink      cfg
);
    gcpd_pkg::cfg_t    cfg_live;
    gcpd_pkg::result_t res;
    logic              res_load;
    logic              res_space;

    gcpd_cfg_regs #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_live)
    );

    gcpd_core #(
        .MAX_CODE_BITS  (MAX_CODE_BITS),
        .CAM_COORD_BITS (CAM_COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .cfg       (cfg_live),
        .res_space (res_space),
        .res_load  (res_load),
        .res       (res)
    );

    gcpd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .res_space (res_space),
        .result    (result)
    );
endmodule

### rtl/gcpd_cfg_regs.sv
module gcpd_cfg_regs #(
    parameter int MAX_CODE_BITS = gcpd_pkg::DEF_MAX_CODE_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    gcpd_cfg_if.sink           cfg,
    output gcpd_pkg::cfg_t     cfg_out
);
    localparam int CODE_W = (MAX_CODE_BITS < 16) ? MAX_CODE_BITS : 16;
    localparam logic [gcpd_pkg::BITS_W-1:0] BITS_LIM = gcpd_pkg::BITS_W'(CODE_W);

    gcpd_pkg::cfg_t cfg_reg;

    // Bit counts are stored already clamped to 1 .. CODE_W
    function automatic logic [gcpd_pkg::BITS_W-1:0] clamp_bits(
        input logic [gcpd_pkg::BITS_W-1:0] b
    );
        if (b == '0)
            return gcpd_pkg::BITS_W'(1);
        else if (b > BITS_LIM)
            return BITS_LIM;
        else
            return b;
    endfunction

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_bits        <= clamp_bits(gcpd_pkg::RST_COLUMN_BITS);
            cfg_reg.row_bits           <= clamp_bits(gcpd_pkg::RST_ROW_BITS);
            cfg_reg.contrast_threshold <= gcpd_pkg::RST_CONTRAST;
            cfg_reg.shadow_threshold   <= gcpd_pkg::RST_SHADOW;
            cfg_reg.projector_width    <= gcpd_pkg::RST_PROJ_WIDTH;
            cfg_reg.projector_height   <= gcpd_pkg::RST_PROJ_HEIGHT;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                gcpd_pkg::REG_COLUMN_BITS:
                    cfg_reg.column_bits <= clamp_bits(cfg.data[gcpd_pkg::BITS_W-1:0]);
                gcpd_pkg::REG_ROW_BITS:
                    cfg_reg.row_bits <= clamp_bits(cfg.data[gcpd_pkg::BITS_W-1:0]);
                gcpd_pkg::REG_CONTRAST:
                    cfg_reg.contrast_threshold <= cfg.data[gcpd_pkg::THRESH_W-1:0];
                gcpd_pkg::REG_SHADOW:
                    cfg_reg.shadow_threshold <= cfg.data[gcpd_pkg::THRESH_W-1:0];
                gcpd_pkg::REG_PROJ_WIDTH:
                    cfg_reg.projector_width <= cfg.data[gcpd_pkg::PROJ_SIZE_W-1:0];
                gcpd_pkg::REG_PROJ_HEIGHT:
                    cfg_reg.projector_height <= cfg.data[gcpd_pkg::PROJ_SIZE_W-1:0];
                default:
                    ;
            endcase
        end
    end
endmodule

### rtl/gcpd_core.sv
module gcpd_core #(
    parameter int MAX_CODE_BITS  = gcpd_pkg::DEF_MAX_CODE_BITS,
    parameter int CAM_COORD_BITS = gcpd_pkg::DEF_CAM_COORD_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    gcpd_pixel_if.sink         pixel,
    input  gcpd_pkg::cfg_t     cfg,
    input  logic               res_space,
    output logic               res_load,
    output gcpd_pkg::result_t  res
);
    localparam int CODE_W = (MAX_CODE_BITS < 16) ? MAX_CODE_BITS : 16;
    localparam int LAT_W  = (CAM_COORD_BITS < gcpd_pkg::PIX_W) ?
                            CAM_COORD_BITS : gcpd_pkg::PIX_W;

    // Input register
    logic                         in_valid_reg;
    logic                         in_cmd_reg;
    logic [gcpd_pkg::LEVEL_W-1:0] in_a_reg;
    logic [gcpd_pkg::LEVEL_W-1:0] in_b_reg;
    logic [LAT_W-1:0]             in_row_reg;
    logic [LAT_W-1:0]             in_col_reg;

    // Pixel decode state
    logic                         active_reg, active_next;
    logic [gcpd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         run_reg, run_next;
    logic [CODE_W-1:0]            colv_reg, colv_next;
    logic [CODE_W-1:0]            rowv_reg, rowv_next;
    gcpd_pkg::status_t            err_reg, err_next;
    logic [LAT_W-1:0]             lat_row_reg, lat_row_next;
    logic [LAT_W-1:0]             lat_col_reg, lat_col_next;

    logic                         advance;
    logic                         emit;
    logic                         bit_val;
    logic                         run_base;
    logic [gcpd_pkg::LEVEL_W-1:0] diff;
    logic [gcpd_pkg::COUNT_W-1:0] total;
    gcpd_pkg::status_t            status;

    assign total = gcpd_pkg::COUNT_W'(cfg.column_bits) + gcpd_pkg::COUNT_W'(cfg.row_bits);

    // A transfer leaves the input register unless a result is due and the
    // output register is still full
    assign advance     = in_valid_reg && (!emit || res_space);
    assign pixel.ready = !in_valid_reg || advance;
    assign res_load    = advance && emit;

    always_comb
    begin
        active_next  = active_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        colv_next    = colv_reg;
        rowv_next    = rowv_reg;
        err_next     = err_reg;
        lat_row_next = lat_row_reg;
        lat_col_next = lat_col_reg;
        emit         = 1'b0;
        diff         = gcpd_pkg::abs_diff(in_a_reg, in_b_reg);
        bit_val      = in_a_reg > in_b_reg;
        run_base     = (count_reg == gcpd_pkg::COUNT_W'(cfg.column_bits)) ? 1'b0 : run_reg;

        if (in_cmd_reg == gcpd_pkg::CMD_REF)
        begin
            lat_row_next = in_row_reg;
            lat_col_next = in_col_reg;
            active_next  = 1'b1;
            count_next   = '0;
            run_next     = 1'b0;
            colv_next    = '0;
            rowv_next    = '0;
            err_next     = (diff > cfg.shadow_threshold) ? gcpd_pkg::STATUS_OK
                                                          : gcpd_pkg::STATUS_SHADOW;
        end
        else if (active_reg)
        begin
            if (err_reg == gcpd_pkg::STATUS_OK && diff < cfg.contrast_threshold)
                err_next = gcpd_pkg::STATUS_CONTRAST;
            run_next = run_base ^ bit_val;
            if (count_reg < gcpd_pkg::COUNT_W'(cfg.column_bits))
                colv_next = {colv_reg[CODE_W-2:0], run_next};
            else
                rowv_next = {rowv_reg[CODE_W-2:0], run_next};
            count_next = count_reg + 1'b1;
            if (count_next >= total)
            begin
                emit        = 1'b1;
                active_next = 1'b0;
            end
        end

        status = err_next;
        if (err_next == gcpd_pkg::STATUS_OK &&
            (gcpd_pkg::PROJ_SIZE_W'(rowv_next) >= cfg.projector_height ||
             gcpd_pkg::PROJ_SIZE_W'(colv_next) >= cfg.projector_width))
            status = gcpd_pkg::STATUS_RANGE;

        res.pixel_row = gcpd_pkg::PIX_W'(lat_row_next);
        res.pixel_col = gcpd_pkg::PIX_W'(lat_col_next);
        res.status    = status;
        if (status == gcpd_pkg::STATUS_SHADOW || status == gcpd_pkg::STATUS_CONTRAST)
        begin
            res.proj_row = '0;
            res.proj_col = '0;
        end
        else
        begin
            res.proj_row = gcpd_pkg::PROJ_W'(rowv_next);
            res.proj_col = gcpd_pkg::PROJ_W'(colv_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (pixel.ready)
            in_valid_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
        begin
            in_cmd_reg <= pixel.command;
            in_a_reg   <= pixel.level_a;
            in_b_reg   <= pixel.level_b;
            in_row_reg <= pixel.cam_row[LAT_W-1:0];
            in_col_reg <= pixel.cam_col[LAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            count_reg   <= '0;
            run_reg     <= 1'b0;
            colv_reg    <= '0;
            rowv_reg    <= '0;
            err_reg     <= gcpd_pkg::STATUS_OK;
            lat_row_reg <= '0;
            lat_col_reg <= '0;
        end
        else if (advance)
        begin
            active_reg  <= active_next;
            count_reg   <= count_next;
            run_reg     <= run_next;
            colv_reg    <= colv_next;
            rowv_reg    <= rowv_next;
            err_reg     <= err_next;
            lat_row_reg <= lat_row_next;
            lat_col_reg <= lat_col_next;
        end
    end
endmodule

### rtl/gcpd_out_reg.sv
module gcpd_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_load,
    input  gcpd_pkg::result_t  res,
    output logic               res_space,
    gcpd_result_if.source      result
);
    logic              valid_reg;
    gcpd_pkg::result_t data_reg;

    assign res_space        = !valid_reg || result.ready;
    assign result.valid     = valid_reg;
    assign result.pixel_row = data_reg.pixel_row;
    assign result.pixel_col = data_reg.pixel_col;
    assign result.proj_row  = data_reg.proj_row;
    assign result.proj_col  = data_reg.proj_col;
    assign result.status    = data_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res_load)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            data_reg <= res;
    end
endmodule
